>>> rtl/core/izn_pkg.sv
// shared types, constants and helpers of the izhikevich neuron update block
package izn_pkg;

	localparam int MAX_NEURONS_DEF      = 1024;
	localparam int MOTOR_CHANNELS_DEF   = 5;
	localparam int SENSORY_CHANNELS_DEF = 256;
	localparam int QUEUE_DEPTH          = 2;

	localparam logic [1:0] CFG_NEURON_COUNT  = 2'd0;
	localparam logic [1:0] CFG_SENSORY_COUNT = 2'd1;
	localparam logic [1:0] CFG_MOTOR_COUNT   = 2'd2;

	localparam logic [10:0] NEURON_COUNT_RST  = 11'd1024;
	localparam logic [8:0]  SENSORY_COUNT_RST = 9'd256;
	localparam logic [2:0]  MOTOR_COUNT_RST   = 3'd5;

	localparam logic signed [31:0] V_RESET = -32'sd4259840;
	localparam logic signed [31:0] U_RESET = -32'sd851968;
	localparam logic [10:0]        ACC_MAX = 11'd2047;

	typedef struct packed {
		logic [9:0] neuron_index;
		logic [7:0] sensory_level;
		logic       first_of_step;
	} izn_in_t;

	typedef struct packed {
		logic               spiked;
		logic signed [31:0] membrane_out;
		logic signed [31:0] recovery_out;
		logic [2:0]         motor_channel;
		logic [10:0]        motor_total;
	} izn_out_t;

	typedef struct packed {
		logic [10:0] neuron_count;
		logic [8:0]  sensory_count;
		logic [2:0]  motor_count;
	} izn_cfg_t;

	typedef struct packed {
		logic [9:0] idx;
		logic [7:0] level;
		logic       first;
		logic       in_use;
		logic       in_range;
		logic       sensory;
		logic       chan_ok;
		logic [2:0] chan;
	} izn_work_t;

	function automatic logic signed [31:0] sat32(input logic signed [40:0] x);
		logic signed [31:0] r;
		if (x > 41'sd2147483647) begin
			r = 32'sh7fffffff;
		end else if (x < -41'sd2147483648) begin
			r = 32'sh80000000;
		end else begin
			r = x[31:0];
		end
		return r;
	endfunction

endpackage

>>> rtl/core/izn_chan_if.sv
// valid/ready channel carrying one item
interface izn_chan_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T     data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

>>> rtl/core/izhikevich_neuron_update.sv
// top level of the izhikevich neuron update block
//
// in_ch carries one item per neuron to advance (index, sensory byte,
// first-of-step flag); out_ch returns one result item per input item, in
// order, with the spike flag, new membrane and recovery values (Q16.16),
// motor channel and that channel's spike count this step.
// the front end classifies each item and places it in a two-entry queue;
// the back end reads the neuron state, runs the Euler step as a sequence
// of multiply steps and writes the state back.
// the back end handles one neuron at a time: the state read, five
// registered multiply/round steps and the result register; a neuron not
// in use goes from the first step straight to the result register.
// after reset the state memories are swept to their resting values, one
// neuron per cycle, and in_ch.ready stays low.
// when the receiver stalls the result holds in the output register, the
// back end finishes the next item and waits, and the queue absorbs up to
// two more items before in_ch.ready drops.
// configuration is written through cfg_we/cfg_index/cfg_data; the user must
// write it only while idle, since the block itself leaves this unchecked.
module izhikevich_neuron_update import izn_pkg::*; #(
	parameter int MAX_NEURONS      = MAX_NEURONS_DEF,
	parameter int MOTOR_CHANNELS   = MOTOR_CHANNELS_DEF,
	parameter int SENSORY_CHANNELS = SENSORY_CHANNELS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	izn_chan_if.sink    in_ch,
	izn_chan_if.source  out_ch,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [10:0] cfg_data
);
	izn_cfg_t  cfg_q;
	logic      clearing;
	logic      q_full;
	logic      push;
	izn_work_t push_data;
	logic      pop;
	logic      head_valid;
	izn_work_t head_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.neuron_count  <= NEURON_COUNT_RST;
			cfg_q.sensory_count <= SENSORY_COUNT_RST;
			cfg_q.motor_count   <= MOTOR_COUNT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_NEURON_COUNT:  cfg_q.neuron_count  <= cfg_data;
				CFG_SENSORY_COUNT: cfg_q.sensory_count <= cfg_data[8:0];
				CFG_MOTOR_COUNT:   cfg_q.motor_count   <= cfg_data[2:0];
				default: begin
				end
			endcase
		end
	end

	izn_front #(
		.MAX_NEURONS(MAX_NEURONS),
		.MOTOR_CHANNELS(MOTOR_CHANNELS),
		.SENSORY_CHANNELS(SENSORY_CHANNELS)
	) u_front (
		.cfg(cfg_q),
		.clearing(clearing),
		.q_full(q_full),
		.push(push),
		.push_data(push_data),
		.in_ch(in_ch)
	);

	izn_fifo #(
		.T(izn_work_t),
		.DEPTH(QUEUE_DEPTH)
	) u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_data(push_data),
		.full(q_full),
		.pop(pop),
		.head_valid(head_valid),
		.head_data(head_data)
	);

	izn_back #(
		.MAX_NEURONS(MAX_NEURONS),
		.MOTOR_CHANNELS(MOTOR_CHANNELS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head_valid(head_valid),
		.head_data(head_data),
		.pop(pop),
		.clearing(clearing),
		.out_ch(out_ch)
	);

	a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> !in_ch.ready)
		else $error("item accepted during memory clearing");

	a_no_result_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> !out_ch.valid)
		else $error("result produced during memory clearing");

	a_spike_resets_membrane: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && out_ch.data.spiked) |-> (out_ch.data.membrane_out == V_RESET))
		else $error("spiking neuron not reset to resting membrane");
endmodule

>>> rtl/core/izn_fifo.sv
// short queue between front and back
module izn_fifo import izn_pkg::*; #(
	parameter type T = logic,
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  T     push_data,
	output logic full,
	input  logic pop,
	output logic head_valid,
	output T     head_data
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	T               mem_q [DEPTH];
	logic [PW-1:0]  wr_ptr_q;
	logic [PW-1:0]  rd_ptr_q;
	logic [PW:0]    count_q;

	assign full       = (count_q == (PW+1)'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH-1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH-1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end
endmodule

>>> rtl/core/izn_front.sv
// front end: accepts items and classifies neuron, sensory and motor binning
module izn_front import izn_pkg::*; #(
	parameter int MAX_NEURONS      = MAX_NEURONS_DEF,
	parameter int MOTOR_CHANNELS   = MOTOR_CHANNELS_DEF,
	parameter int SENSORY_CHANNELS = SENSORY_CHANNELS_DEF
) (
	input  izn_cfg_t  cfg,
	input  logic      clearing,
	input  logic      q_full,
	output logic      push,
	output izn_work_t push_data,
	izn_chan_if.sink  in_ch
);
	logic [10:0] n_use;
	logic [8:0]  s_use;
	logic [2:0]  m_use;
	logic [12:0] prod;
	logic [3:0]  chan_cnt;
	izn_in_t     item;

	assign item  = in_ch.data;
	assign n_use = (int'(cfg.neuron_count) < MAX_NEURONS) ? cfg.neuron_count
		: 11'(MAX_NEURONS);
	assign s_use = (int'(cfg.sensory_count) < SENSORY_CHANNELS) ? cfg.sensory_count
		: 9'(SENSORY_CHANNELS);
	assign m_use = (int'(cfg.motor_count) < MOTOR_CHANNELS) ? cfg.motor_count
		: 3'(MOTOR_CHANNELS);
	assign prod  = 13'(item.neuron_index) * 13'(m_use);

	// channel = idx*m/n as a count of thresholds c*n passed
	always_comb begin
		chan_cnt = '0;
		for (int c = 1; c < MOTOR_CHANNELS; c++) begin
			if (c < int'(m_use) && (15'(c) * 15'(n_use) <= 15'(prod))) begin
				chan_cnt = chan_cnt + 4'd1;
			end
		end
	end

	assign in_ch.ready = !clearing && !q_full;
	assign push        = in_ch.valid && in_ch.ready;

	always_comb begin
		push_data.idx      = item.neuron_index;
		push_data.level    = item.sensory_level;
		push_data.first    = item.first_of_step;
		push_data.in_use   = {1'b0, item.neuron_index} < n_use;
		push_data.in_range = int'(item.neuron_index) < MAX_NEURONS;
		push_data.sensory  = item.neuron_index < 10'(s_use);
		push_data.chan_ok  = (m_use != '0);
		push_data.chan     = (m_use != '0) ? 3'(chan_cnt) : '0;
	end
endmodule

>>> rtl/core/izn_back.sv
// back end: state memories, euler step sequence, motor counts, result register
module izn_back import izn_pkg::*; #(
	parameter int MAX_NEURONS    = MAX_NEURONS_DEF,
	parameter int MOTOR_CHANNELS = MOTOR_CHANNELS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       head_valid,
	input  izn_work_t  head_data,
	output logic       pop,
	output logic       clearing,
	izn_chan_if.source out_ch
);
	localparam int AW = (MAX_NEURONS > 1) ? $clog2(MAX_NEURONS) : 1;
	localparam int CW = (MOTOR_CHANNELS > 1) ? $clog2(MOTOR_CHANNELS) : 1;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_SQ   = 3'd1;
	localparam logic [2:0] ST_T    = 3'd2;
	localparam logic [2:0] ST_SUM  = 3'd3;
	localparam logic [2:0] ST_MUL  = 3'd4;
	localparam logic [2:0] ST_U    = 3'd5;
	localparam logic [2:0] ST_FIN  = 3'd6;

	logic [2:0]         state_q;
	izn_work_t          item_q;
	logic signed [31:0] mem_v [MAX_NEURONS];
	logic signed [31:0] mem_u [MAX_NEURONS];
	logic signed [31:0] v_q;
	logic signed [31:0] u_q;
	logic               clr_busy_q;
	logic [AW-1:0]      clr_addr_q;
	logic signed [47:0] sq_q;
	logic signed [43:0] t_q;
	logic signed [41:0] sum_q;
	logic signed [32:0] r3_q;
	logic signed [40:0] vn_q;
	logic signed [29:0] a_q;
	logic signed [31:0] un_q;
	logic [10:0]        acc_q [MOTOR_CHANNELS];
	logic               out_valid_q;
	izn_out_t           out_q;

	logic signed [63:0] p_sq, sq_r;
	logic signed [60:0] p_t, t_r;
	logic [20:0]        i_mag;
	logic signed [45:0] sum_w;
	logic signed [41:0] sum_c;
	logic signed [46:0] p_r, r_r;
	logic signed [32:0] r3_w;
	logic signed [55:0] p_v, v_r;
	logic signed [44:0] p_a, a_r;
	logic signed [43:0] p_u, u_r;
	logic signed [40:0] u1_w;
	logic               spike;
	logic signed [31:0] v_new, u_new;
	logic [CW-1:0]      cidx;
	logic [10:0]        acc_cur, acc_next;
	logic               fire;
	logic               count_en;
	izn_out_t           out_w;

	assign p_sq = v_q * v_q;
	assign sq_r = (p_sq + 64'sd32768) >>> 16;
	assign p_t  = sq_q * 13'sd2621;
	assign t_r  = (p_t + 61'sd32768) >>> 16;

	assign i_mag = item_q.sensory ? 21'(item_q.level) * 21'd6554 : '0;
	assign sum_w = 46'(t_q) + 46'(v_q) * 46'sd5 + 46'sd9175040 - 46'(u_q)
		+ $signed({25'b0, i_mag});
	assign sum_c = (sum_w > 46'sd1099511627776) ? 42'sd1099511627776
		: (sum_w < -46'sd1099511627776) ? -42'sd1099511627776 : sum_w[41:0];

	assign p_r  = v_q * 16'sd13107;
	assign r_r  = (p_r + 47'sd32768) >>> 16;
	assign r3_w = 33'($signed(r_r[31:0])) - 33'(u_q);

	assign p_v = sum_q * 16'sd6554;
	assign v_r = (p_v + 56'sd32768) >>> 16;
	assign p_a = r3_q * 16'sd1311;
	assign a_r = (p_a + 45'sd32768) >>> 16;
	assign p_u = a_q * 16'sd6554;
	assign u_r = (p_u + 44'sd32768) >>> 16;
	assign u1_w = 41'(u_q) + $signed(u_r[40:0]);

	assign spike = (vn_q >= 41'sd1966080);
	assign v_new = spike ? V_RESET : sat32(vn_q);
	assign u_new = spike ? sat32(41'(un_q) + 41'sd524288) : un_q;

	assign cidx     = CW'(item_q.chan);
	assign acc_cur  = acc_q[cidx];
	assign acc_next = (spike && acc_cur != ACC_MAX) ? acc_cur + 11'd1 : acc_cur;
	assign count_en = item_q.in_use && item_q.chan_ok;

	assign pop      = (state_q == ST_IDLE) && !clr_busy_q && head_valid;
	assign fire     = (state_q == ST_FIN) && (!out_valid_q || out_ch.ready);
	assign clearing = clr_busy_q;

	always_comb begin
		out_w.spiked        = item_q.in_use && spike;
		out_w.membrane_out  = item_q.in_use ? v_new : (item_q.in_range ? v_q : '0);
		out_w.recovery_out  = item_q.in_use ? u_new : (item_q.in_range ? u_q : '0);
		out_w.motor_channel = count_en ? item_q.chan : '0;
		out_w.motor_total   = count_en ? acc_next : '0;
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.data  = out_q;

	// state memories with clearing pass after reset
	always_ff @(posedge clk) begin
		if (clr_busy_q) begin
			mem_v[clr_addr_q] <= V_RESET;
			mem_u[clr_addr_q] <= U_RESET;
		end else if (fire && item_q.in_use) begin
			mem_v[AW'(item_q.idx)] <= v_new;
			mem_u[AW'(item_q.idx)] <= u_new;
		end
		if (pop) begin
			v_q <= mem_v[AW'(head_data.idx)];
			u_q <= mem_u[AW'(head_data.idx)];
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			item_q <= head_data;
		end
		unique case (state_q)
			ST_SQ: begin
				sq_q <= sq_r[47:0];
			end
			ST_T: begin
				t_q <= t_r[43:0];
			end
			ST_SUM: begin
				sum_q <= sum_c;
				r3_q  <= r3_w;
			end
			ST_MUL: begin
				vn_q <= 41'(v_q) + $signed(v_r[40:0]);
				a_q  <= a_r[29:0];
			end
			ST_U: begin
				un_q <= sat32(u1_w);
			end
			default: begin
			end
		endcase
		if (fire) begin
			out_q <= out_w;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			clr_busy_q  <= 1'b1;
			clr_addr_q  <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < MOTOR_CHANNELS; i++) begin
				acc_q[i] <= '0;
			end
		end else begin
			if (clr_busy_q) begin
				if (clr_addr_q == AW'(MAX_NEURONS - 1)) begin
					clr_busy_q <= 1'b0;
				end
				clr_addr_q <= clr_addr_q + 1'b1;
			end
			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (pop) begin
						state_q <= ST_SQ;
						if (head_data.first) begin
							for (int i = 0; i < MOTOR_CHANNELS; i++) begin
								acc_q[i] <= '0;
							end
						end
					end
				end
				ST_SQ:  state_q <= item_q.in_use ? ST_T : ST_FIN;
				ST_T:   state_q <= ST_SUM;
				ST_SUM: state_q <= ST_MUL;
				ST_MUL: state_q <= ST_U;
				ST_U:   state_q <= ST_FIN;
				ST_FIN: begin
					if (fire) begin
						state_q <= ST_IDLE;
						if (count_en) begin
							acc_q[cidx] <= acc_next;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule
